/* rtl/core/fijb_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Frame input jitter buffer package
// Shared constants, result codes, slot layout and scan handshake types.
// ----------------------------------------------------------------------------
package fijb_pkg;

    // Ring depth is a power of two so the slot index is the low frame bits.
    localparam int SLOT_W   = 6;
    localparam int CAPACITY = 2 ** SLOT_W;

    localparam logic [31:0] CAP_32    = 32'(CAPACITY);
    localparam logic [31:0] CAP_M1_32 = 32'(CAPACITY - 1);

    localparam logic [3:0] PAYLOAD_BYTES_RST = 4'd8;

    localparam logic OP_STORE  = 1'b0;
    localparam logic OP_SELECT = 1'b1;

    localparam logic [2:0] KIND_STORED   = 3'd0;
    localparam logic [2:0] KIND_REJECTED = 3'd1;
    localparam logic [2:0] KIND_FRESH    = 3'd2;
    localparam logic [2:0] KIND_REUSED   = 3'd3;
    localparam logic [2:0] KIND_NONE     = 3'd4;

    typedef struct packed {
        logic [31:0] tag;
        logic [3:0]  len;
        logic [63:0] data;
    } t_slot;

    typedef struct packed {
        logic        go;
        logic [31:0] due;
        logic [31:0] start;
    } t_scan_req;

    typedef struct packed {
        logic        done;
        logic        found;
        logic [31:0] frame;
        logic [63:0] data;
        logic [3:0]  len;
    } t_scan_res;

    // Keep the low n bytes; n of 8 or more keeps all of them.
    function automatic logic [63:0] byte_mask(input logic [3:0] n);
        logic [63:0] m;
        for (int b = 0; b < 8; b++) begin
            m[b*8 +: 8] = (4'(b) < n) ? 8'hFF : 8'h00;
        end
        return m;
    endfunction

endpackage
`default_nettype wire

/* rtl/core/fijb_ram.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module fijb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

/* rtl/core/fijb_scan.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Frame input jitter buffer slot scanner
// Walks frames from the due frame down to the window start, one slot read a
// cycle, and checks each returned slot in one shared tag/length comparator.
// ----------------------------------------------------------------------------
module fijb_scan (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire fijb_pkg::t_scan_req       i_req,
    input  wire logic [3:0]                i_payload_bytes,
    input  wire fijb_pkg::t_slot           i_rd_slot,
    input  wire logic                      i_rd_valid,
    output logic [fijb_pkg::SLOT_W-1:0]    o_rd_addr,
    output fijb_pkg::t_scan_res            o_res
);
    import fijb_pkg::*;

    logic        r_issue;
    logic        r_cmp_vld;
    logic [31:0] r_cur;
    logic [31:0] r_start;
    logic [31:0] r_cmp_frame;
    logic        hit;

    assign o_rd_addr = r_cur[SLOT_W-1:0];

    // Shared comparator: slot returned for the frame issued last cycle.
    always_comb begin
        hit = r_cmp_vld && i_rd_valid && (i_rd_slot.tag == r_cmp_frame)
              && (i_rd_slot.len == i_payload_bytes);
        o_res.done  = r_cmp_vld && (hit || !r_issue);
        o_res.found = hit;
        o_res.frame = r_cmp_frame;
        o_res.data  = i_rd_slot.data;
        o_res.len   = i_rd_slot.len;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_issue   <= 1'b0;
            r_cmp_vld <= 1'b0;
        end else if (i_req.go) begin
            r_issue   <= 1'b1;
            r_cmp_vld <= 1'b0;
            r_cur     <= i_req.due;
            r_start   <= i_req.start;
        end else if (o_res.done) begin
            r_issue   <= 1'b0;
            r_cmp_vld <= 1'b0;
        end else begin
            r_cmp_vld <= r_issue;
            if (r_issue) begin
                r_cmp_frame <= r_cur;
                if (r_cur == r_start) begin
                    r_issue <= 1'b0;
                end else begin
                    r_cur <= r_cur - 32'd1;
                end
            end
        end
    end

endmodule
`default_nettype wire

/* rtl/core/frame_input_jitter_buffer_top.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Frame input jitter buffer
// Frame-indexed ring of per-frame input payloads with fresh/reuse selection.
// ----------------------------------------------------------------------------
// A store item's result strobes on the next cycle and busy never rises, so
// stores may be issued back to back. A select item walks the window from the
// due frame down to max(last applied + 1, due - CAPACITY + 1, 1), one slot
// memory read per cycle through the single read port, and stops at the first
// matching slot. An empty window settles in S_PREP without a scan; otherwise
// the scan runs in S_SCAN. Busy is high from the cycle after start until the
// result strobe. Each result is on the o_ ports for exactly one cycle with
// o_strobe high and cannot be held off, so capture it on that cycle. The
// counters and highest stored frame show their values after that item. Write
// payload_bytes only while the block is idle.
// ----------------------------------------------------------------------------
module frame_input_jitter_buffer_top (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic        i_cfg_we,
    input  wire logic [3:0]  i_cfg_wdata,
    input  wire logic        i_operation,
    input  wire logic [31:0] i_frame_number,
    input  wire logic [63:0] i_payload,
    output logic             o_strobe,
    output logic [2:0]       o_result_kind,
    output logic [31:0]      o_chosen_frame,
    output logic [63:0]      o_chosen_payload,
    output logic [31:0]      o_highest_stored,
    output logic [31:0]      o_starved_total,
    output logic [31:0]      o_reused_total,
    output logic [31:0]      o_applied_total
);
    import fijb_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_PREP,
        S_SCAN
    } t_state;

    t_state              r_state;
    logic [3:0]          r_payload_bytes;
    logic [CAPACITY-1:0] r_slot_valid;
    logic                r_rd_valid;
    logic [31:0]         r_ack;
    logic [31:0]         r_due;
    logic [31:0]         r_lower;
    logic [31:0]         r_applied_frame;
    logic [63:0]         r_applied_data;
    logic [3:0]          r_applied_len;
    logic                r_has_applied;
    logic [31:0]         r_starve_cnt;
    logic [31:0]         r_reuse_cnt;
    logic [31:0]         r_apply_cnt;
    logic                r_strobe;
    logic [2:0]          r_kind;
    logic [31:0]         r_chosen_frame;
    logic [63:0]         r_chosen_data;

    logic              accept;
    logic              store_ok;
    logic              ram_we;
    t_slot             ram_wslot;
    t_slot             ram_rslot;
    logic [SLOT_W-1:0] rd_addr;
    logic [31:0]       n_start;
    logic              empty_win;
    logic              resolve;
    logic              sel_found;
    t_scan_req         scan_req;
    t_scan_res         scan_res;

    assign busy   = (r_state != S_IDLE);
    assign accept = start && !busy;

    // Store path: reject frame zero and a zero size, mask unused bytes.
    assign store_ok  = (i_frame_number != 32'd0) && (r_payload_bytes != 4'd0);
    assign ram_we    = accept && (i_operation == OP_STORE) && store_ok;
    assign ram_wslot = '{tag:  i_frame_number,
                         len:  r_payload_bytes,
                         data: i_payload & byte_mask(r_payload_bytes)};

    // Window start: newest of the frame after the applied one and the ring bound.
    always_comb begin
        n_start   = ((r_applied_frame + 32'd1) > r_lower) ? (r_applied_frame + 32'd1)
                                                          : r_lower;
        empty_win = (n_start > r_due);
    end

    assign scan_req = '{go: (r_state == S_PREP) && !empty_win, due: r_due, start: n_start};

    assign resolve   = ((r_state == S_PREP) && empty_win)
                       || ((r_state == S_SCAN) && scan_res.done);
    assign sel_found = (r_state == S_SCAN) && scan_res.found;

    fijb_ram #(
        .WIDTH ($bits(t_slot)),
        .DEPTH (CAPACITY)
    ) u_slot_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (i_frame_number[SLOT_W-1:0]),
        .i_wdata (ram_wslot),
        .i_raddr (rd_addr),
        .o_rdata (ram_rslot)
    );

    fijb_scan u_scan (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_req           (scan_req),
        .i_payload_bytes (r_payload_bytes),
        .i_rd_slot       (ram_rslot),
        .i_rd_valid      (r_rd_valid),
        .o_rd_addr       (rd_addr),
        .o_res           (scan_res)
    );

    // Valid bit travels with the registered slot read.
    always_ff @(posedge i_clk) begin
        r_rd_valid <= r_slot_valid[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= S_IDLE;
            r_payload_bytes <= PAYLOAD_BYTES_RST;
            r_slot_valid    <= '0;
            r_ack           <= '0;
            r_applied_frame <= '0;
            r_applied_data  <= '0;
            r_applied_len   <= '0;
            r_has_applied   <= 1'b0;
            r_starve_cnt    <= '0;
            r_reuse_cnt     <= '0;
            r_apply_cnt     <= '0;
            r_strobe        <= 1'b0;
        end else begin
            // Strobe for one cycle after each store and each settled select.
            r_strobe <= (accept && (i_operation == OP_STORE)) || resolve;
            if (i_cfg_we) begin
                r_payload_bytes <= i_cfg_wdata;
            end
            case (r_state)
                S_IDLE: begin
                    if (accept && (i_operation == OP_STORE)) begin
                        r_chosen_frame <= '0;
                        r_chosen_data  <= '0;
                        if (store_ok) begin
                            r_kind <= KIND_STORED;
                            r_slot_valid[i_frame_number[SLOT_W-1:0]] <= 1'b1;
                            if (i_frame_number > r_ack) begin
                                r_ack <= i_frame_number;
                            end
                        end else begin
                            r_kind <= KIND_REJECTED;
                        end
                    end else if (accept) begin
                        r_due   <= i_frame_number;
                        r_lower <= (i_frame_number > CAP_32) ? (i_frame_number - CAP_M1_32)
                                                             : 32'd1;
                        r_state <= S_PREP;
                    end
                end
                S_PREP: begin
                    if (!empty_win) begin
                        r_state <= S_SCAN;
                    end
                end
                S_SCAN: begin
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase

            // Settle a select: apply the fresh slot, else reuse, else nothing.
            if (resolve) begin
                r_state  <= S_IDLE;
                if (sel_found) begin
                    r_kind          <= KIND_FRESH;
                    r_chosen_frame  <= scan_res.frame;
                    r_chosen_data   <= scan_res.data;
                    r_applied_frame <= scan_res.frame;
                    r_applied_data  <= scan_res.data;
                    r_applied_len   <= scan_res.len;
                    r_has_applied   <= 1'b1;
                    r_apply_cnt     <= r_apply_cnt + 32'd1;
                    if (scan_res.frame != r_due) begin
                        r_starve_cnt <= r_starve_cnt + 32'd1;
                    end
                end else if (r_has_applied && (r_applied_len == r_payload_bytes)) begin
                    r_kind         <= KIND_REUSED;
                    r_chosen_frame <= r_applied_frame;
                    r_chosen_data  <= r_applied_data;
                    r_starve_cnt   <= r_starve_cnt + 32'd1;
                    r_reuse_cnt    <= r_reuse_cnt + 32'd1;
                end else begin
                    r_kind         <= KIND_NONE;
                    r_chosen_frame <= '0;
                    r_chosen_data  <= '0;
                    r_starve_cnt   <= r_starve_cnt + 32'd1;
                end
            end
        end
    end

    assign o_strobe         = r_strobe;
    assign o_result_kind    = r_kind;
    assign o_chosen_frame   = r_chosen_frame;
    assign o_chosen_payload = r_chosen_data;
    assign o_highest_stored = r_ack;
    assign o_starved_total  = r_starve_cnt;
    assign o_reused_total   = r_reuse_cnt;
    assign o_applied_total  = r_apply_cnt;

    // Every accepted store answers on the very next cycle.
    a_store_answers: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && (i_operation == OP_STORE)) |=> o_strobe)
        else $error("store item without result strobe");

    // The scanner only reports while the sequencer waits for it.
    a_scan_done_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        scan_res.done |-> (r_state == S_SCAN))
        else $error("scan result outside scan state");

    // No slot write while a select is in flight.
    a_no_write_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |-> !ram_we)
        else $error("slot write during select");

    // Applied count moves only with a fresh result.
    a_apply_with_fresh: assert property (@(posedge i_clk)
        disable iff (!i_rst_n || !$past(i_rst_n))
        (r_apply_cnt != $past(r_apply_cnt)) |-> (o_strobe && (o_result_kind == KIND_FRESH)))
        else $error("applied count changed without fresh result");

endmodule
`default_nettype wire

/* tb/sv/frame_input_jitter_buffer_top_tb.sv */
// ----------------------------------------------------------------------------
// Frame input jitter buffer testbench
// Drives store and select items through the start/busy handshake and predicts
// every result. Each strobed result is compared field by field with the
// oldest outstanding prediction. The run starts with directed corner cases,
// then switches through several payload sizes. Each size runs a stream of
// jittered stores and due-frame selects, mixed with some arbitrary items.
// ----------------------------------------------------------------------------
module frame_input_jitter_buffer_top_tb;

    import fijb_pkg::*;

    // Cycles without any accepted item, result or register write before giving up.
    localparam int STALL_LIMIT = 2000;
    localparam int N_SESSIONS  = 10;

    typedef struct {
        logic [2:0]  kind;
        logic [31:0] frame;
        logic [63:0] payload;
        logic [31:0] highest;
        logic [31:0] starved;
        logic [31:0] reused;
        logic [31:0] applied;
    } frame_result_t;

    // Tracks the ring, the applied payload and the counters, and holds the
    // results still owed by the block in issue order.
    class jitter_scoreboard;
        bit [31:0]     slot_tag   [CAPACITY];
        bit            slot_valid [CAPACITY];
        bit [3:0]      slot_len   [CAPACITY];
        bit [63:0]     slot_data  [CAPACITY];
        bit [31:0]     highest_frame;
        bit [31:0]     last_frame;
        bit [63:0]     last_data;
        bit [3:0]      last_len;
        bit            have_last;
        bit [31:0]     starved_cnt;
        bit [31:0]     reused_cnt;
        bit [31:0]     applied_cnt;
        bit [3:0]      size = PAYLOAD_BYTES_RST;
        frame_result_t owed [$];
        int            errors;
        int            n_results;

        function void set_size(logic [3:0] value);
            size = value;
        endfunction

        function int pending();
            return owed.size();
        endfunction

        // Work out the result of one accepted item and queue it.
        function void note_item(logic op, logic [31:0] frame, logic [63:0] data);
            frame_result_t r;
            int unsigned   idx;
            bit [31:0]     lower;
            bit [31:0]     first;
            bit [31:0]     f;
            bit            scanning;
            bit            found;
            r = '{default: '0};
            found = 1'b0;
            if (op == OP_STORE) begin
                if (frame == 32'd0 || size == 4'd0) begin
                    r.kind = KIND_REJECTED;
                end else begin
                    idx = frame % CAPACITY;
                    slot_tag[idx]   = frame;
                    slot_valid[idx] = 1'b1;
                    slot_len[idx]   = size;
                    // Clear the bytes above the configured size.
                    slot_data[idx]  = (size >= 4'd8) ? data
                                    : data & ((64'd1 << (8 * size)) - 64'd1);
                    if (frame > highest_frame)
                        highest_frame = frame;
                    r.kind = KIND_STORED;
                end
            end else begin
                lower = (frame > CAP_32) ? frame - CAP_M1_32 : 32'd1;
                first = last_frame + 32'd1;
                if (first < lower)
                    first = lower;
                // Walk down from the due frame, newest first.
                scanning = (first <= frame);
                f = frame;
                while (scanning) begin
                    idx = f % CAPACITY;
                    if (slot_valid[idx] && slot_tag[idx] == f && slot_len[idx] == size) begin
                        found = 1'b1;
                        scanning = 1'b0;
                    end else if (f == first) begin
                        scanning = 1'b0;
                    end else begin
                        f = f - 32'd1;
                    end
                end
                if (found) begin
                    last_frame = f;
                    last_data  = slot_data[idx];
                    last_len   = slot_len[idx];
                    have_last  = 1'b1;
                    applied_cnt++;
                    if (f < frame)
                        starved_cnt++;
                    r.kind    = KIND_FRESH;
                    r.frame   = f;
                    r.payload = last_data;
                end else if (have_last && last_len == size) begin
                    starved_cnt++;
                    reused_cnt++;
                    r.kind    = KIND_REUSED;
                    r.frame   = last_frame;
                    r.payload = last_data;
                end else begin
                    starved_cnt++;
                    r.kind = KIND_NONE;
                end
            end
            r.highest = highest_frame;
            r.starved = starved_cnt;
            r.reused  = reused_cnt;
            r.applied = applied_cnt;
            owed.push_back(r);
        endfunction

        task report_mismatch(string msg);
            $display("MISMATCH at result %0d: %s", n_results, msg);
            errors++;
        endtask

        task compare_field(string field, logic [63:0] got, logic [63:0] want);
            if (got !== want)
                report_mismatch($sformatf("%s is 0x%0h, predicted 0x%0h", field, got, want));
        endtask

        task check_result(frame_result_t got);
            frame_result_t want;
            if (owed.size() == 0) begin
                report_mismatch($sformatf("result kind %0d frame 0x%0h with nothing owed",
                                          got.kind, got.frame));
                return;
            end
            want = owed.pop_front();
            compare_field("result_kind",      got.kind,    want.kind);
            compare_field("chosen_frame",     got.frame,   want.frame);
            compare_field("chosen_payload",   got.payload, want.payload);
            compare_field("highest_stored",   got.highest, want.highest);
            compare_field("starved_total",    got.starved, want.starved);
            compare_field("reused_total",     got.reused,  want.reused);
            compare_field("applied_total",    got.applied, want.applied);
            n_results++;
        endtask
    endclass

    logic        i_clk;
    logic        i_rst_n        = 1'b0;
    logic        start          = 1'b0;
    logic        busy;
    logic        i_cfg_we       = 1'b0;
    logic [3:0]  i_cfg_wdata    = 4'd0;
    logic        i_operation    = OP_STORE;
    logic [31:0] i_frame_number = 32'd0;
    logic [63:0] i_payload      = 64'd0;
    logic        o_strobe;
    logic [2:0]  o_result_kind;
    logic [31:0] o_chosen_frame;
    logic [63:0] o_chosen_payload;
    logic [31:0] o_highest_stored;
    logic [31:0] o_starved_total;
    logic [31:0] o_reused_total;
    logic [31:0] o_applied_total;

    jitter_scoreboard sb = new;

    int idle_cycles = 0;
    int items_sent  = 0;
    int burst_left  = 8;
    bit steady      = 1'b0;

    frame_input_jitter_buffer_top u_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .busy             (busy),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_wdata      (i_cfg_wdata),
        .i_operation      (i_operation),
        .i_frame_number   (i_frame_number),
        .i_payload        (i_payload),
        .o_strobe         (o_strobe),
        .o_result_kind    (o_result_kind),
        .o_chosen_frame   (o_chosen_frame),
        .o_chosen_payload (o_chosen_payload),
        .o_highest_stored (o_highest_stored),
        .o_starved_total  (o_starved_total),
        .o_reused_total   (o_reused_total),
        .o_applied_total  (o_applied_total)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Sample everything at the rising edge, before this edge's updates land:
    // check a strobed result, note an accepted item, track register writes.
    always @(posedge i_clk) begin : monitor
        frame_result_t seen;
        if (i_rst_n) begin
            if (o_strobe) begin
                seen.kind    = o_result_kind;
                seen.frame   = o_chosen_frame;
                seen.payload = o_chosen_payload;
                seen.highest = o_highest_stored;
                seen.starved = o_starved_total;
                seen.reused  = o_reused_total;
                seen.applied = o_applied_total;
                sb.check_result(seen);
            end
            if (start && !busy)
                sb.note_item(i_operation, i_frame_number, i_payload);
            if (i_cfg_we)
                sb.set_size(i_cfg_wdata);
        end
        if (o_strobe || (start && !busy) || i_cfg_we)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    // End the run when the block stops making progress.
    initial begin
        while (idle_cycles < STALL_LIMIT)
            @(posedge i_clk);
        $display("Stall: no handshake for %0d cycles", STALL_LIMIT);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    function automatic logic [63:0] any_payload();
        case ($urandom_range(0, 5))
            0:       return 64'd0;
            1:       return '1;
            default: return {$urandom(), $urandom()};
        endcase
    endfunction

    // Present one item and hold it until the block takes it. Close the burst
    // when its count runs out: drop start for a random gap, unless in a
    // steady stretch where items follow back to back.
    task automatic send_item(input logic op, input logic [31:0] frame,
                             input logic [63:0] data);
        int gap;
        start          <= 1'b1;
        i_operation    <= op;
        i_frame_number <= frame;
        i_payload      <= data;
        do @(posedge i_clk); while (busy);
        items_sent++;
        burst_left--;
        if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 24);
            if (!steady) begin
                gap = ($urandom_range(0, 6) == 0) ? $urandom_range(20, 80)
                                                  : $urandom_range(1, 6);
                start <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    // Stop sending and hold until every owed result has come back.
    task automatic wait_drained();
        start <= 1'b0;
        do @(posedge i_clk); while (sb.pending() != 0);
    endtask

    // Change the payload size only once the block has gone quiet.
    task automatic set_payload_size(input logic [3:0] value);
        wait_drained();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    // One stretch at a fixed payload size. Model the network: deliver frames
    // a little ahead of the due frame, out of order, with drops, late
    // duplicates and the odd skip, then select the due frame and advance it.
    // Sprinkle in arbitrary items as noise.
    task automatic run_session(input logic [3:0] value, input int n_items, input bit calm);
        logic [31:0] due;
        logic [31:0] frame;
        int          stop_at;
        set_payload_size(value);
        steady  = calm;
        stop_at = items_sent + n_items;
        case ($urandom_range(0, 3))
            0:       due = sb.last_frame + 32'($urandom_range(1, 4));
            1:       due = 32'($urandom_range(1, 300));
            2:       due = 32'hFFFF_FFFF - 32'($urandom_range(0, 150));
            default: due = 32'($urandom());
        endcase
        while (items_sent < stop_at) begin
            if ($urandom_range(0, 99) < 8) begin
                case ($urandom_range(0, 3))
                    0:       frame = 32'($urandom());
                    1:       frame = 32'($urandom_range(0, 2));
                    2:       frame = ~32'($urandom_range(0, 2));
                    default: frame = 32'($urandom_range(0, 400));
                endcase
                send_item(1'($urandom_range(0, 1)), frame, any_payload());
            end else begin
                if ($urandom_range(0, 9) < 8)
                    send_item(OP_STORE, due + 32'($urandom_range(0, 3)), any_payload());
                if ($urandom_range(0, 19) == 0)
                    send_item(OP_STORE, due - 32'($urandom_range(1, 80)), any_payload());
                if ($urandom_range(0, 9) != 0)
                    send_item(OP_SELECT, due, any_payload());
                case ($urandom_range(0, 49))
                    0:       due = due + 32'($urandom_range(60, 200));
                    1, 2:    due = due + 32'($urandom_range(2, 10));
                    3:       ;  // hold the due frame so the next select repeats it
                    default: due = due + 32'd1;
                endcase
                if ($urandom_range(0, 99) == 0)
                    wait_drained();
            end
        end
    endtask

    initial begin
        logic [3:0] value;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Empty buffer: nothing to hand out, and due frame zero scans nothing.
        send_item(OP_SELECT, 32'd5, 64'd0);
        send_item(OP_SELECT, 32'd0, '1);
        // Frame zero is refused and leaves the state alone.
        send_item(OP_STORE, 32'd0, '1);
        send_item(OP_STORE, 32'd1, '1);
        send_item(OP_STORE, 32'd3, 64'h0123_4567_89AB_CDEF);
        // Pick the newest match, then reuse it once the window is empty.
        send_item(OP_SELECT, 32'd3, 64'd0);
        send_item(OP_SELECT, 32'd3, '1);
        send_item(OP_SELECT, 32'd2, 64'd0);
        // Top frame number, then a select whose window start wraps past zero.
        send_item(OP_STORE, 32'hFFFF_FFFF, 64'h8000_0000_0000_0001);
        send_item(OP_SELECT, 32'hFFFF_FFFF, 64'd0);
        send_item(OP_SELECT, 32'hFFFF_FFFF, 64'd0);
        send_item(OP_SELECT, 32'd5, 64'd0);
        // Full window of stale slots: reuse the last payload.
        send_item(OP_SELECT, 32'd200, 64'd0);

        // Short payload: upper bytes must come back cleared.
        set_payload_size(4'd3);
        send_item(OP_STORE, 32'd10, '1);
        send_item(OP_SELECT, 32'd12, 64'd0);
        // Zero size: stores refused, nothing matches, last payload length differs.
        set_payload_size(4'd0);
        send_item(OP_STORE, 32'd14, '1);
        send_item(OP_SELECT, 32'd14, 64'd0);
        // Oversize keeps all eight bytes; overwrite a slot with a later frame.
        set_payload_size(4'd15);
        send_item(OP_STORE, 32'd20, '1);
        send_item(OP_STORE, 32'd84, 64'h5A5A_A5A5_0F0F_F0F0);
        send_item(OP_SELECT, 32'd84, 64'd0);
        set_payload_size(4'd1);
        send_item(OP_STORE, 32'd90, 64'hFFFF_FFFF_FFFF_FFFE);
        send_item(OP_SELECT, 32'd95, 64'd0);
        // Back to full size: slot and last payload lengths no longer match.
        set_payload_size(4'd8);
        send_item(OP_SELECT, 32'd96, 64'd0);

        // Random stretches across the size range, two of them without gaps.
        for (int s = 0; s < N_SESSIONS; s++) begin
            case (s)
                0, 5, 9: value = 4'd8;
                1:       value = 4'd1;
                2:       value = 4'd15;
                3:       value = 4'd4;
                4:       value = 4'd0;
                6:       value = 4'd2;
                7:       value = 4'd7;
                default: value = 4'($urandom_range(0, 15));
            endcase
            run_session(value, (value == 4'd0) ? 40 : 140, s == 2 || s == 6);
        end

        // Let the last results land, then watch for strays.
        wait_drained();
        repeat (80) @(posedge i_clk);
        if (sb.errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
